FILE: rtl/hdwc_pkg.sv
package hdwc_pkg;

  // field widths
  localparam int HUM_W      = 10;
  localparam int PCT_W      = 7;
  localparam int LVL_W      = 8;
  localparam int TIME_W     = 32;
  localparam int DEV_W      = 10;
  localparam int TEN_W      = PCT_W + 4;   // percent scaled to tenths
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 10;

  // arithmetic widths, fixed by the field ranges
  localparam int DSQ_W  = 2 * DEV_W;       // dev^2
  localparam int FSQ_W  = 2 * PCT_W;       // F^2
  localparam int QD_W   = 21;              // 100*F^2
  localparam int FN_W   = 12;              // 26*m
  localparam int QN_W   = 28;              // 255*dev^2
  localparam int QN10_W = 32;              // 2550*dev^2
  localparam int D255_W = 29;              // 255*den
  localparam int REST_W = 29;              // 255*den - num, magnitude
  localparam int LVL_QW = 9;               // quotient bits for a power level

  localparam int MUL_AW = QD_W;
  localparam int MUL_BW = FN_W;
  localparam int MUL_PW = MUL_AW + MUL_BW;

  // scale constants
  localparam int FULL_POWER    = 255;
  localparam int PCT_TO_TENTHS = 10;
  localparam int QD_SCALE      = 100;
  localparam int FLOOR_NUM     = 26;
  localparam int FLOOR_DEN     = 10;
  localparam int QN10_SCALE    = FULL_POWER * FLOOR_DEN;

  localparam logic [LVL_W-1:0] LVL_MAX = 8'hFF;

  // register reset values
  localparam logic [HUM_W-1:0] TARGET_RST = 10'd600;
  localparam logic [PCT_W-1:0] FULL_RST   = 7'd10;
  localparam logic [PCT_W-1:0] BAND_RST   = 7'd1;
  localparam logic [PCT_W-1:0] MINP_RST   = 7'd10;

  // PWM defaults
  localparam int ON_TIME_MS_DEF  = 1000;
  localparam int OFF_DIVISOR_DEF = 8;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TARGET,
    CFG_FULL,
    CFG_BAND,
    CFG_MINP
  } cfg_idx_t;

  typedef enum logic {
    KIND_REFRESH,
    KIND_WAIT
  } kind_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_PREP,
    S_MUL_DEV,
    S_MUL_F,
    S_MUL_FQ_GO,
    S_MUL_FQ,
    S_DIV_LVL_GO,
    S_DIV_LVL,
    S_DIV_OFF_GO,
    S_DIV_OFF,
    S_OUT
  } state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

endpackage

FILE: rtl/hdwc_ser_mul.sv
module hdwc_ser_mul import hdwc_pkg::*; #(
  parameter int AW = MUL_AW,
  parameter int BW = MUL_BW
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [AW-1:0]    a,
  input  logic [BW-1:0]    b,
  output logic [AW+BW-1:0] product,
  output unit_stat_t       stat
);

  localparam int CW = $clog2(BW + 1);

  logic [AW-1:0]    a_r, a_nxt;
  logic [AW+BW-1:0] p_r, p_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [AW:0]      sum;

  // shift-add, multiplier bits consumed LSB first from the low half of p_r
  always_comb begin
    sum      = {1'b0, p_r[AW+BW-1:BW]} + (p_r[0] ? {1'b0, a_r} : '0);
    a_nxt    = a_r;
    p_nxt    = p_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      a_nxt    = a;
      p_nxt    = {{AW{1'b0}}, b};
      cnt_nxt  = CW'(BW);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      p_nxt   = {sum, p_r[BW-1:1]};
      cnt_nxt = cnt_r - CW'(1);
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    a_r <= a_nxt;
    p_r <= p_nxt;
  end

  assign product   = p_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule

FILE: rtl/hdwc_ser_div.sv
module hdwc_ser_div import hdwc_pkg::*; #(
  parameter int DW = QD_W + 4,
  parameter int QW = LVL_QW
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DW+QW-1:0] dividend,
  input  logic [DW-1:0]    divisor,
  output logic [QW-1:0]    quotient,
  output unit_stat_t       stat
);

  localparam int CW = $clog2(QW + 1);

  // caller guarantees dividend < divisor * 2^QW, so the top part starts below divisor
  logic [DW-1:0] rem_r, rem_nxt;
  logic [QW-1:0] quo_r, quo_nxt;
  logic [DW-1:0] dv_r, dv_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [DW:0]   trial;
  logic [DW:0]   diff;
  logic          ge;

  // restoring division, one quotient bit a cycle; low dividend bits shift
  // out of quo_r while quotient bits shift in
  always_comb begin
    trial    = {rem_r, quo_r[QW-1]};
    diff     = trial - {1'b0, dv_r};
    ge       = (trial >= {1'b0, dv_r});
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dv_nxt   = dv_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt  = dividend[DW+QW-1:QW];
      quo_nxt  = dividend[QW-1:0];
      dv_nxt   = divisor;
      cnt_nxt  = CW'(QW);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt = ge ? diff[DW-1:0] : trial[DW-1:0];
      quo_nxt = {quo_r[QW-2:0], ge};
      cnt_nxt = cnt_r - CW'(1);
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dv_r  <= dv_nxt;
  end

  assign quotient  = quo_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule

FILE: rtl/humidity_dry_wet_controller_unit.sv
// Humidity dry/wet controller.
// Input channel (in_*): one beat per refresh or wait. A refresh carries a
// humidity sample, its valid flag and a millisecond timestamp; a wait turns
// fan and evaporator off. Each input beat yields exactly one output beat
// (out_*) with fan drive, reported dry and wet levels and the evaporator switch.
// Config channel (cfg_*): cfg_index selects target, full-scale deviation,
// deadband or minimum power; always ready, write only while idle.
// When no power has to be computed (wait, bad sample, deadband, full
// scale), the item goes from the prep step straight to the output step.
// Inside the proportional band it runs through one bit-serial multiplier
// (three products) and one bit-serial restoring divider (one or two
// quotients of 15 bits at default PWM settings).
// One item is in flight at a time; the next beat is taken once the result
// sits in the output register, even while the receiver stalls. A stalled
// output holds its beat; the following item then waits in the last step.
// Reset (synchronous, active low) loads the register defaults, zeroes fan,
// dry and wet levels, switches the evaporator off and clears the PWM phase start.
module humidity_dry_wet_controller_unit import hdwc_pkg::*; #(
  parameter int ON_TIME_MS  = ON_TIME_MS_DEF,
  parameter int OFF_DIVISOR = OFF_DIVISOR_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  in_kind,
  input  logic [HUM_W-1:0]      in_humidity_tenths,
  input  logic                  in_sample_ok,
  input  logic [TIME_W-1:0]     in_now_ms,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [LVL_W-1:0]      out_fan_speed,
  output logic [LVL_W-1:0]      out_dry_level,
  output logic [LVL_W-1:0]      out_wet_level,
  output logic                  out_evaporator_on,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int OD_W    = $clog2(OFF_DIVISOR + 1);
  localparam int OFF_QW  = $clog2(FULL_POWER * ON_TIME_MS / OFF_DIVISOR + 1);
  localparam int DIV_QW  = (OFF_QW > LVL_QW) ? OFF_QW : LVL_QW;
  localparam int DIV_DW  = QD_W + OD_W;
  localparam int DIV_NW  = DIV_DW + DIV_QW;

  // config registers
  logic [HUM_W-1:0] target_r;
  logic [PCT_W-1:0] full_r, band_r, minp_r;

  // controller state
  logic [LVL_W-1:0]  fan_r, fan_nxt;
  logic [LVL_W-1:0]  dry_r, dry_nxt;
  logic [LVL_W-1:0]  wet_r, wet_nxt;
  logic              evap_r, evap_nxt;
  logic [TIME_W-1:0] phase_r, phase_nxt;

  // item in flight
  state_t            state_r, state_nxt;
  logic              kind_r, ok_r;
  logic [HUM_W-1:0]  hum_r;
  logic [TIME_W-1:0] now_r;
  logic              dry_side_r, dry_side_nxt;
  logic [DSQ_W-1:0]  dsq_r, dsq_nxt;
  logic [FSQ_W-1:0]  fsq_r, fsq_nxt;
  logic              use_floor_r, use_floor_nxt;
  logic [LVL_W-1:0]  lvl_r, lvl_nxt;
  logic [REST_W:0]   rest_r, rest_nxt;

  // output register
  logic              out_valid_r, out_valid_nxt;
  logic [LVL_W-1:0]  o_fan_r, o_dry_r, o_wet_r;
  logic              o_evap_r;
  logic              out_load;

  logic              in_accept;

  // datapath
  logic              hum_gt, hum_lt;
  logic [DEV_W-1:0]  dev;
  logic [TEN_W-1:0]  full10, band10;
  logic              at_full, in_band;
  logic [QD_W-1:0]   qd;
  logic [QN_W-1:0]   qn;
  logic [FN_W-1:0]   fn;
  logic [QN10_W-1:0] qn10;
  logic [QN_W-1:0]   n_sel;
  logic [QD_W-1:0]   d_sel;
  logic [D255_W-1:0] d255;
  logic [REST_W:0]   rest_calc;
  logic [DIV_NW-1:0] off_num;
  logic [DIV_DW-1:0] off_den;
  logic [TIME_W-1:0] elapsed;
  logic [TIME_W-1:0] off_time;
  logic [LVL_W-1:0]  q_lvl;

  // arithmetic units
  logic              mul_start;
  logic [MUL_AW-1:0] mul_a;
  logic [MUL_BW-1:0] mul_b;
  logic [MUL_PW-1:0] mul_prod;
  unit_stat_t        mul_stat;
  logic              div_start;
  logic [DIV_NW-1:0] div_dividend;
  logic [DIV_DW-1:0] div_divisor;
  logic [DIV_QW-1:0] div_quot;
  unit_stat_t        div_stat;

  hdwc_ser_mul #(
    .AW (MUL_AW),
    .BW (MUL_BW)
  ) u_mul (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (mul_start),
    .a       (mul_a),
    .b       (mul_b),
    .product (mul_prod),
    .stat    (mul_stat)
  );

  hdwc_ser_div #(
    .DW (DIV_DW),
    .QW (DIV_QW)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .quotient (div_quot),
    .stat     (div_stat)
  );

  assign in_ready  = (state_r == S_IDLE);
  assign in_accept = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_r <= TARGET_RST;
      full_r   <= FULL_RST;
      band_r   <= BAND_RST;
      minp_r   <= MINP_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_TARGET: target_r <= cfg_data[HUM_W-1:0];
        CFG_FULL:   full_r   <= cfg_data[PCT_W-1:0];
        CFG_BAND:   band_r   <= cfg_data[PCT_W-1:0];
        CFG_MINP:   minp_r   <= cfg_data[PCT_W-1:0];
      endcase
    end
  end

  // deviation and band limits
  assign hum_gt  = (hum_r > target_r);
  assign hum_lt  = (hum_r < target_r);
  assign dev     = hum_gt ? (hum_r - target_r) : (target_r - hum_r);
  assign full10  = TEN_W'(full_r) * TEN_W'(PCT_TO_TENTHS);
  assign band10  = TEN_W'(band_r) * TEN_W'(PCT_TO_TENTHS);
  assign at_full = (TEN_W'(dev) >= full10);
  assign in_band = (TEN_W'(dev) <= band10);

  // power = max(255*dev^2 / (100*F^2), 26*m/10), kept as num/den
  assign qd    = QD_W'(fsq_r) * QD_W'(QD_SCALE);
  assign qn    = QN_W'(dsq_r) * QN_W'(FULL_POWER);
  assign fn    = FN_W'(minp_r) * FN_W'(FLOOR_NUM);
  assign qn10  = QN10_W'(dsq_r) * QN10_W'(QN10_SCALE);
  assign n_sel = use_floor_r ? QN_W'(fn) : qn;
  assign d_sel = use_floor_r ? QD_W'(FLOOR_DEN) : qd;

  // off time = (255*den - num) * ON / (OD * den); negative rest means full power
  assign d255      = D255_W'(d_sel) * D255_W'(FULL_POWER);
  assign rest_calc = (REST_W+1)'(d255) - (REST_W+1)'(n_sel);
  assign off_num   = DIV_NW'(rest_r[REST_W-1:0]) * DIV_NW'(ON_TIME_MS);
  assign off_den   = DIV_DW'(d_sel) * DIV_DW'(OFF_DIVISOR);
  assign elapsed   = now_r - phase_r;
  assign off_time  = TIME_W'(div_quot);
  assign q_lvl     = (|div_quot[DIV_QW-1:LVL_W]) ? LVL_MAX : div_quot[LVL_W-1:0];

  assign div_dividend = (state_r == S_DIV_OFF_GO) ? off_num : DIV_NW'(n_sel);
  assign div_divisor  = (state_r == S_DIV_OFF_GO) ? off_den : DIV_DW'(d_sel);

  always_comb begin
    unique case (state_r)
      S_PREP: begin
        mul_a = MUL_AW'(dev);
        mul_b = MUL_BW'(dev);
      end
      S_MUL_DEV: begin
        mul_a = MUL_AW'(full_r);
        mul_b = MUL_BW'(full_r);
      end
      default: begin
        mul_a = qd;
        mul_b = fn;
      end
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    fan_nxt       = fan_r;
    dry_nxt       = dry_r;
    wet_nxt       = wet_r;
    evap_nxt      = evap_r;
    phase_nxt     = phase_r;
    dry_side_nxt  = dry_side_r;
    dsq_nxt       = dsq_r;
    fsq_nxt       = fsq_r;
    use_floor_nxt = use_floor_r;
    lvl_nxt       = lvl_r;
    rest_nxt      = rest_r;
    mul_start     = 1'b0;
    div_start     = 1'b0;
    out_load      = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_PREP;
        end
      end
      S_PREP: begin
        state_nxt = S_OUT;
        priority if (kind_r == KIND_WAIT) begin
          fan_nxt  = '0;
          dry_nxt  = '0;
          wet_nxt  = '0;
          evap_nxt = 1'b0;
        end else if (!ok_r) begin
          wet_nxt  = '0;
          evap_nxt = 1'b0;
        end else if (hum_gt) begin
          wet_nxt      = '0;
          evap_nxt     = 1'b0;
          dry_side_nxt = 1'b1;
          if (at_full) begin
            fan_nxt = LVL_MAX;
            dry_nxt = LVL_MAX;
          end else if (!in_band) begin
            mul_start = 1'b1;
            state_nxt = S_MUL_DEV;
          end
        end else if (hum_lt) begin
          fan_nxt      = '0;
          dry_nxt      = '0;
          dry_side_nxt = 1'b0;
          if (at_full) begin
            wet_nxt  = LVL_MAX;
            evap_nxt = 1'b1;
          end else if (!in_band) begin
            mul_start = 1'b1;
            state_nxt = S_MUL_DEV;
          end
        end else begin
          fan_nxt  = '0;
          dry_nxt  = '0;
          wet_nxt  = '0;
          evap_nxt = 1'b0;
        end
      end
      S_MUL_DEV: begin
        if (mul_stat.done) begin
          dsq_nxt   = mul_prod[DSQ_W-1:0];
          mul_start = 1'b1;
          state_nxt = S_MUL_F;
        end
      end
      S_MUL_F: begin
        if (mul_stat.done) begin
          fsq_nxt   = mul_prod[FSQ_W-1:0];
          state_nxt = S_MUL_FQ_GO;
        end
      end
      S_MUL_FQ_GO: begin
        mul_start = 1'b1;
        state_nxt = S_MUL_FQ;
      end
      S_MUL_FQ: begin
        if (mul_stat.done) begin
          // floor wins when 255*dev^2*10 < 26*m*100*F^2
          use_floor_nxt = (MUL_PW'(qn10) < mul_prod);
          state_nxt     = S_DIV_LVL_GO;
        end
      end
      S_DIV_LVL_GO: begin
        div_start = 1'b1;
        state_nxt = S_DIV_LVL;
      end
      S_DIV_LVL: begin
        if (div_stat.done) begin
          lvl_nxt  = q_lvl;
          rest_nxt = rest_calc;
          if (dry_side_r) begin
            fan_nxt   = q_lvl;
            dry_nxt   = q_lvl;
            state_nxt = S_OUT;
          end else begin
            state_nxt = S_DIV_OFF_GO;
          end
        end
      end
      S_DIV_OFF_GO: begin
        if (rest_r[REST_W]) begin
          wet_nxt   = LVL_MAX;
          evap_nxt  = 1'b1;
          state_nxt = S_OUT;
        end else begin
          div_start = 1'b1;
          state_nxt = S_DIV_OFF;
        end
      end
      S_DIV_OFF: begin
        if (div_stat.done) begin
          state_nxt = S_OUT;
          // off phase shorter than the on phase: run continuously
          if (off_time < TIME_W'(ON_TIME_MS)) begin
            wet_nxt  = LVL_MAX;
            evap_nxt = 1'b1;
          end else begin
            wet_nxt = lvl_r;
            if (evap_r) begin
              if (elapsed >= TIME_W'(ON_TIME_MS)) begin
                phase_nxt = now_r;
                evap_nxt  = 1'b0;
              end
            end else if (elapsed >= off_time) begin
              phase_nxt = now_r;
              evap_nxt  = 1'b1;
            end
          end
        end
      end
      S_OUT: begin
        if (!out_valid_r || out_ready) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r && !out_ready;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      fan_r       <= '0;
      dry_r       <= '0;
      wet_r       <= '0;
      evap_r      <= 1'b0;
      phase_r     <= '0;
      out_valid_r <= 1'b0;
      dry_side_r  <= 1'b0;
      use_floor_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fan_r       <= fan_nxt;
      dry_r       <= dry_nxt;
      wet_r       <= wet_nxt;
      evap_r      <= evap_nxt;
      phase_r     <= phase_nxt;
      out_valid_r <= out_valid_nxt;
      dry_side_r  <= dry_side_nxt;
      use_floor_r <= use_floor_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      kind_r <= in_kind;
      hum_r  <= in_humidity_tenths;
      ok_r   <= in_sample_ok;
      now_r  <= in_now_ms;
    end
    dsq_r  <= dsq_nxt;
    fsq_r  <= fsq_nxt;
    lvl_r  <= lvl_nxt;
    rest_r <= rest_nxt;
    if (out_load) begin
      o_fan_r  <= fan_r;
      o_dry_r  <= dry_r;
      o_wet_r  <= wet_r;
      o_evap_r <= evap_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_fan_speed     = o_fan_r;
  assign out_dry_level     = o_dry_r;
  assign out_wet_level     = o_wet_r;
  assign out_evaporator_on = o_evap_r;

  a_fan_dry_track: assert property (@(posedge clk) disable iff (!rst_n)
    fan_r == dry_r)
    else $error("fan level and dry report diverged");

  a_accept_to_prep: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> state_r == S_PREP)
    else $error("accepted beat did not enter prep");

  a_mul_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    mul_stat.done |-> (state_r == S_MUL_DEV || state_r == S_MUL_F || state_r == S_MUL_FQ))
    else $error("multiplier finished outside a multiply step");

  a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    div_stat.done |-> (state_r == S_DIV_LVL || state_r == S_DIV_OFF))
    else $error("divider finished outside a divide step");

  a_units_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    !(mul_stat.busy && div_stat.busy))
    else $error("multiplier and divider busy together");

endmodule
